[rtl/core/bqcc_pkg.sv]
// ----------------------------------------------------------------------------
// bqcc_pkg
// Shared types and character codes for the brace / quote / comment checker.
// ----------------------------------------------------------------------------
package bqcc_pkg;

	localparam int DEPTH_WIDTH_DEF = 16;
	localparam int UNIT_WIDTH      = 16;

	typedef enum logic [1:0] {
		MODE_NORMAL  = 2'd0,
		MODE_SINGLE  = 2'd1,
		MODE_DOUBLE  = 2'd2,
		MODE_COMMENT = 2'd3
	} scan_mode_t;

	typedef logic [UNIT_WIDTH-1:0] unit_t;

	// step: a word is consumed by the scanner this cycle
	typedef struct packed {
		logic step;
		logic last;
	} scan_ctl_t;

	localparam unit_t CH_STAR   = 16'h002A;
	localparam unit_t CH_SLASH  = 16'h002F;
	localparam unit_t CH_BSLASH = 16'h005C;
	localparam unit_t CH_SQUOTE = 16'h0027;
	localparam unit_t CH_DQUOTE = 16'h0022;
	localparam unit_t CH_LBRACE = 16'h007B;
	localparam unit_t CH_RBRACE = 16'h007D;

endpackage

[rtl/core/bqcc_scan.sv]
// ----------------------------------------------------------------------------
// bqcc_scan
// Scanner state and its per-word update; produces the verdict for the
// word that closes a stream.
// ----------------------------------------------------------------------------
module bqcc_scan #(
	parameter int DEPTH_WIDTH = bqcc_pkg::DEPTH_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  bqcc_pkg::scan_ctl_t ctl,
	input  bqcc_pkg::unit_t     code,
	output logic                verdict
);
	import bqcc_pkg::*;

	scan_mode_t             mode_q, mode_n;
	logic                   esc_q, esc_n;
	logic                   slash_q, slash_n;
	logic                   star_q, star_n;
	logic [DEPTH_WIDTH-1:0] depth_q, depth_n;
	logic                   failed_q, failed_n;

	always_comb begin
		mode_n   = mode_q;
		esc_n    = esc_q;
		slash_n  = slash_q;
		star_n   = star_q;
		depth_n  = depth_q;
		failed_n = failed_q;
		if (!failed_q) begin
			case (mode_q)
				MODE_COMMENT: begin
					if (star_q && code == CH_SLASH) begin
						star_n = 1'b0;
						mode_n = MODE_NORMAL;
					end else begin
						star_n = (code == CH_STAR);
					end
				end
				MODE_SINGLE, MODE_DOUBLE: begin
					if (esc_q) begin
						esc_n = 1'b0;
					end else if (code == CH_BSLASH) begin
						esc_n = 1'b1;
					end else if ((mode_q == MODE_SINGLE && code == CH_SQUOTE) ||
					             (mode_q == MODE_DOUBLE && code == CH_DQUOTE)) begin
						mode_n = MODE_NORMAL;
					end
				end
				MODE_NORMAL: begin
					slash_n = 1'b0;
					if (slash_q && code == CH_STAR) begin
						mode_n = MODE_COMMENT;
						star_n = 1'b0;
					end else if (code == CH_SLASH) begin
						slash_n = 1'b1;
					end else if (code == CH_SQUOTE) begin
						mode_n = MODE_SINGLE;
						esc_n  = 1'b0;
					end else if (code == CH_DQUOTE) begin
						mode_n = MODE_DOUBLE;
						esc_n  = 1'b0;
					end else if (code == CH_LBRACE) begin
						// counter full counts as overflow
						if (&depth_q) failed_n = 1'b1;
						else          depth_n  = depth_q + 1'b1;
					end else if (code == CH_RBRACE) begin
						if (depth_q == '0) failed_n = 1'b1;
						else               depth_n  = depth_q - 1'b1;
					end
				end
				default: begin
					mode_n = MODE_NORMAL;
				end
			endcase
		end
	end

	assign verdict = !failed_n && mode_n == MODE_NORMAL && depth_n == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_NORMAL;
			esc_q    <= 1'b0;
			slash_q  <= 1'b0;
			star_q   <= 1'b0;
			depth_q  <= '0;
			failed_q <= 1'b0;
		end else if (ctl.step) begin
			if (ctl.last) begin
				mode_q   <= MODE_NORMAL;
				esc_q    <= 1'b0;
				slash_q  <= 1'b0;
				star_q   <= 1'b0;
				depth_q  <= '0;
				failed_q <= 1'b0;
			end else begin
				mode_q   <= mode_n;
				esc_q    <= esc_n;
				slash_q  <= slash_n;
				star_q   <= star_n;
				depth_q  <= depth_n;
				failed_q <= failed_n;
			end
		end
	end

	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && ctl.last |=> mode_q == MODE_NORMAL && depth_q == '0 && !failed_q
			&& !slash_q && !star_q)
		else $error("scanner state not cleared after last word");

	a_fail_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		failed_q && !(ctl.step && ctl.last) |=> failed_q)
		else $error("failure flag dropped inside a stream");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.step |=> $stable(depth_q) && $stable(mode_q) && $stable(failed_q))
		else $error("scanner state moved without a word");

	a_depth_only_normal: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.step && !ctl.last && mode_q != MODE_NORMAL |=> $stable(depth_q))
		else $error("brace depth changed outside normal mode");

endmodule

[rtl/core/brace_quote_comment_checker_core.sv]
// ----------------------------------------------------------------------------
// brace_quote_comment_checker_core
// Streaming checker for balanced braces, closed quotes and closed comments.
// ----------------------------------------------------------------------------
// Takes one 16-bit code unit per cycle while not stalled, back to back,
// with no gaps needed between streams. Each word is latched in an input
// register and consumed by the scanner from there; the word flagged
// last_unit loads a single well_formed verdict into the result register
// when the scanner consumes it, and the scanner starts the next stream
// clean on the following word. The input stalls only while a verdict is
// waiting downstream and the next last word would need the result
// register. Brace depth is DEPTH_WIDTH bits; a full counter on an opening
// brace or a closing brace at zero fails the stream.
module brace_quote_comment_checker_core #(
	parameter int DEPTH_WIDTH = bqcc_pkg::DEPTH_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  bqcc_pkg::unit_t code_unit,
	input  logic            last_unit,
	output logic            result_valid,
	input  logic            result_stall,
	output logic            well_formed
);
	import bqcc_pkg::*;

	logic      valid_s1;
	unit_t     code_s1;
	logic      last_s1;
	logic      res_valid_q;
	logic      res_q;
	logic      verdict;
	logic      accept;
	scan_ctl_t ctl;

	// a last word may advance only if the result register is free or draining
	assign ctl.step  = valid_s1 && !(last_s1 && res_valid_q && result_stall);
	assign ctl.last  = last_s1;
	assign item_stall = valid_s1 && !ctl.step;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (ctl.step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			code_s1 <= code_unit;
			last_s1 <= last_unit;
		end
	end

	bqcc_scan #(
		.DEPTH_WIDTH(DEPTH_WIDTH)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.code    (code_s1),
		.verdict (verdict)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.step && ctl.last) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && ctl.last) begin
			res_q <= verdict;
		end
	end

	assign result_valid = res_valid_q;
	assign well_formed  = res_q;

endmodule

[test/tb_brace_quote_comment_checker_core.sv]
// ----------------------------------------------------------------------------
// tb_brace_quote_comment_checker_core
// Self-checking bench for the brace / quote / comment checker core. Text
// streams go in one word at a time and each verdict is compared with a
// cycle-free scan model kept in a small scoreboard. Short hand-made streams
// come first, then random streams: mostly well-formed text, some of it broken
// on purpose, plus noise and brace floods that run the depth counter over.
// Both handshakes idle and stall in random bursts, except in the final part.
// ----------------------------------------------------------------------------
module tb_brace_quote_comment_checker_core;
	import bqcc_pkg::*;

	// narrow counter so that overflow is reachable with short streams
	localparam int DEPTH_W    = 4;
	localparam int RAND_WORDS = 1650;
	localparam int QUIET_FROM = 1400;
	localparam int CYCLE_CAP  = 300000;

	logic  clk;
	logic  arst_n;
	logic  item_valid;
	logic  item_stall;
	unit_t code_unit;
	logic  last_unit;
	logic  result_valid;
	logic  result_stall;
	logic  well_formed;

	brace_quote_comment_checker_core #(
		.DEPTH_WIDTH(DEPTH_W)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.code_unit    (code_unit),
		.last_unit    (last_unit),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.well_formed  (well_formed)
	);

	class verdict_scoreboard;
		scan_mode_t         mode;
		bit                 esc_pend;
		bit                 slash_pend;
		bit                 star_pend;
		bit                 failed;
		logic [DEPTH_W-1:0] depth;
		bit                 verdict_q[$];
		int                 errors;
		int                 good_cnt;
		int                 bad_cnt;

		function void clear_scan();
			mode       = MODE_NORMAL;
			esc_pend   = 1'b0;
			slash_pend = 1'b0;
			star_pend  = 1'b0;
			failed     = 1'b0;
			depth      = '0;
		endfunction

		function new();
			clear_scan();
			errors   = 0;
			good_cnt = 0;
			bad_cnt  = 0;
		endfunction

		// scan one accepted word; queue a verdict when it closes the stream
		function void note_word(unit_t u, bit is_last);
			bit opened;
			bit ok;
			opened = 1'b0;
			if (!failed) begin
				case (mode)
					MODE_COMMENT: begin
						if (star_pend && u == CH_SLASH) begin
							star_pend = 1'b0;
							mode      = MODE_NORMAL;
						end else begin
							star_pend = (u == CH_STAR);
						end
					end
					MODE_SINGLE, MODE_DOUBLE: begin
						if (esc_pend)
							esc_pend = 1'b0;
						else if (u == CH_BSLASH)
							esc_pend = 1'b1;
						else if ((mode == MODE_SINGLE && u == CH_SQUOTE) ||
							(mode == MODE_DOUBLE && u == CH_DQUOTE))
							mode = MODE_NORMAL;
					end
					default: begin
						if (slash_pend) begin
							slash_pend = 1'b0;
							if (u == CH_STAR) begin
								mode      = MODE_COMMENT;
								star_pend = 1'b0;
								opened    = 1'b1;
							end
						end
						if (!opened) begin
							if (u == CH_SLASH) begin
								slash_pend = 1'b1;
							end else if (u == CH_SQUOTE) begin
								mode     = MODE_SINGLE;
								esc_pend = 1'b0;
							end else if (u == CH_DQUOTE) begin
								mode     = MODE_DOUBLE;
								esc_pend = 1'b0;
							end else if (u == CH_LBRACE) begin
								if (depth == '1)
									failed = 1'b1;
								else
									depth = depth + 1'b1;
							end else if (u == CH_RBRACE) begin
								if (depth == '0)
									failed = 1'b1;
								else
									depth = depth - 1'b1;
							end
						end
					end
				endcase
			end
			if (is_last) begin
				ok = !failed && mode == MODE_NORMAL && depth == '0;
				verdict_q.push_back(ok);
				clear_scan();
			end
		endfunction

		task report(string what);
			$display("mismatch: %s", what);
			errors++;
		endtask

		task check_verdict(logic got);
			bit want;
			if (verdict_q.size() == 0) begin
				report($sformatf("verdict %b with none pending", got));
			end else begin
				want = verdict_q.pop_front();
				if (want) good_cnt++; else bad_cnt++;
				if (got !== want)
					report($sformatf("well_formed got %b want %b", got, want));
			end
		endtask
	endclass

	verdict_scoreboard sb;
	unit_t             stream_q[$];
	bit                quiet;
	int                cycles;
	int                stream_cnt;
	int                word_cnt;

	initial clk = 1'b0;
	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_CAP) begin
			$display("tb: failure");
			$finish;
		end
	end

	// sample both handshakes on the edge that accepts
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_word(code_unit, last_unit);
			if (result_valid && !result_stall)
				sb.check_verdict(well_formed);
		end
	end

	// result-side backpressure
	initial begin
		result_stall = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if (quiet) begin
				result_stall <= 1'b0;
				@(posedge clk);
			end else if ($urandom_range(0, 3) == 0) begin
				result_stall <= 1'b1;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end else begin
				result_stall <= 1'b0;
				repeat ($urandom_range(1, 20)) @(posedge clk);
			end
		end
	end

	function automatic bit is_special(unit_t u);
		return u == CH_STAR || u == CH_SLASH || u == CH_BSLASH || u == CH_SQUOTE ||
			u == CH_DQUOTE || u == CH_LBRACE || u == CH_RBRACE;
	endfunction

	function automatic unit_t plain_unit();
		unit_t u;
		do begin
			if ($urandom_range(0, 1) == 0)
				u = unit_t'($urandom_range(0, 16'h7F));
			else
				u = unit_t'($urandom_range(0, 16'hFFFF));
		end while (is_special(u));
		return u;
	endfunction

	function automatic unit_t special_unit();
		case ($urandom_range(0, 6))
			0: return CH_STAR;
			1: return CH_SLASH;
			2: return CH_BSLASH;
			3: return CH_SQUOTE;
			4: return CH_DQUOTE;
			5: return CH_LBRACE;
			default: return CH_RBRACE;
		endcase
	endfunction

	function automatic unit_t any_unit();
		return ($urandom_range(0, 1) == 0) ? special_unit() : plain_unit();
	endfunction

	function automatic void add_quoted(unit_t q);
		unit_t u;
		stream_q.push_back(q);
		repeat ($urandom_range(0, 5)) begin
			case ($urandom_range(0, 3))
				0: begin
					stream_q.push_back(CH_BSLASH);
					stream_q.push_back(any_unit());
				end
				1: begin
					u = special_unit();
					stream_q.push_back((u == q || u == CH_BSLASH) ? plain_unit() : u);
				end
				default: stream_q.push_back(plain_unit());
			endcase
		end
		stream_q.push_back(q);
	endfunction

	function automatic void add_comment();
		unit_t u;
		bit    prev_star;
		prev_star = 1'b0;
		stream_q.push_back(CH_SLASH);
		stream_q.push_back(CH_STAR);
		repeat ($urandom_range(0, 5)) begin
			u = any_unit();
			if (prev_star && u == CH_SLASH)
				u = plain_unit();
			stream_q.push_back(u);
			prev_star = (u == CH_STAR);
		end
		stream_q.push_back(CH_STAR);
		stream_q.push_back(CH_SLASH);
	endfunction

	function automatic void gen_balanced();
		int lvl;
		int max_lvl;
		lvl     = 0;
		max_lvl = (1 << DEPTH_W) - 1;
		repeat ($urandom_range(1, 12)) begin
			case ($urandom_range(0, 6))
				0, 1: begin
					if (lvl < max_lvl) begin
						stream_q.push_back(CH_LBRACE);
						lvl++;
					end else begin
						stream_q.push_back(plain_unit());
					end
				end
				2: begin
					if (lvl > 0) begin
						stream_q.push_back(CH_RBRACE);
						lvl--;
					end else begin
						stream_q.push_back(plain_unit());
					end
				end
				3: add_quoted(CH_SQUOTE);
				4: add_quoted(CH_DQUOTE);
				5: add_comment();
				default: begin
					// a lone slash is harmless when a plain unit follows it
					if ($urandom_range(0, 2) == 0)
						stream_q.push_back(CH_SLASH);
					stream_q.push_back(plain_unit());
				end
			endcase
		end
		repeat (lvl) stream_q.push_back(CH_RBRACE);
	endfunction

	function automatic void break_stream();
		int pos;
		pos = $urandom_range(0, stream_q.size() - 1);
		case ($urandom_range(0, 3))
			0: stream_q[pos] = special_unit();
			1: if (stream_q.size() > 1) stream_q.delete(pos);
			2: while (stream_q.size() > pos + 1) void'(stream_q.pop_back());
			default: stream_q.insert(pos, special_unit());
		endcase
	endfunction

	function automatic void gen_noise();
		int k;
		if ($urandom_range(0, 2) == 0) begin
			// deep enough to hit the counter ceiling now and then
			k = $urandom_range(12, 18);
			repeat (k) stream_q.push_back(CH_LBRACE);
			repeat ($urandom_range(0, k + 1)) stream_q.push_back(CH_RBRACE);
		end else begin
			repeat ($urandom_range(1, 20)) stream_q.push_back(any_unit());
		end
	endfunction

	task automatic send_word(unit_t u, bit is_last);
		if (!quiet && $urandom_range(0, 7) == 0) begin
			item_valid <= 1'b0;
			code_unit  <= unit_t'($urandom);
			last_unit  <= 1'($urandom_range(0, 1));
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		item_valid <= 1'b1;
		code_unit  <= u;
		last_unit  <= is_last;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic send_stream();
		foreach (stream_q[i])
			send_word(stream_q[i], i == stream_q.size() - 1);
		stream_cnt++;
		word_cnt += stream_q.size();
		stream_q.delete();
	endtask

	// hold the input until every pending verdict is out
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.verdict_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		int  rand_words;
		int  pick;
		bit  pressed;
		sb         = new();
		quiet      = 1'b0;
		cycles     = 0;
		stream_cnt = 0;
		word_cnt   = 0;
		rand_words = 0;
		pressed    = 1'b0;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		code_unit  = '0;
		last_unit  = 1'b0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// hand-made streams
		stream_q = '{CH_LBRACE, 16'hFFFF, CH_RBRACE};
		send_stream();
		stream_q = '{CH_RBRACE, CH_LBRACE};               // underflow sticks
		send_stream();
		stream_q = '{CH_LBRACE};                          // left open
		send_stream();
		stream_q = '{CH_SLASH, CH_STAR, CH_SLASH, 16'h0078, CH_STAR, CH_SLASH};
		send_stream();
		stream_q = '{CH_SQUOTE, CH_BSLASH, CH_SQUOTE, CH_SQUOTE};
		send_stream();
		stream_q = '{CH_DQUOTE, CH_BSLASH, CH_DQUOTE, CH_DQUOTE};
		send_stream();
		stream_q = '{CH_DQUOTE, 16'h0000};                // unclosed quote
		send_stream();
		stream_q = '{CH_SLASH};                           // slash left pending
		send_stream();
		stream_q = '{CH_SLASH, CH_STAR, CH_STAR};         // star left pending
		send_stream();
		stream_q = '{CH_SLASH, CH_SLASH, CH_STAR, CH_STAR, CH_SLASH};
		send_stream();
		drain();

		while (rand_words < RAND_WORDS) begin
			if (!pressed && rand_words >= RAND_WORDS / 2) begin
				drain();
				pressed = 1'b1;
			end
			quiet = (rand_words >= QUIET_FROM);
			pick  = $urandom_range(0, 9);
			if (pick < 7) begin
				gen_balanced();
			end else if (pick < 9) begin
				gen_balanced();
				break_stream();
			end else begin
				gen_noise();
			end
			rand_words += stream_q.size();
			send_stream();
		end

		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.verdict_q.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.verdict_q.size() != 0)
			sb.report($sformatf("%0d verdicts never arrived", sb.verdict_q.size()));

		$display("covered %0d streams, %0d words: %0d well-formed, %0d rejected verdicts",
			stream_cnt, word_cnt, sb.good_cnt, sb.bad_cnt);
		if (sb.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
rtl/core/bqcc_pkg.sv
rtl/core/bqcc_scan.sv
rtl/core/brace_quote_comment_checker_core.sv
test/tb_brace_quote_comment_checker_core.sv
